// ----- hdl/lru_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

    localparam int ENTRIES   = 16;
    localparam int TAG_BITS  = 64;
    localparam int DATA_W    = 64;
    localparam int KEY_W     = 64;
    localparam int CAP_W     = 5;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef logic [ENTRIES-1:0] entry_vec_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic search;
        logic update;
    } lru_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/lru_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lru_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire               m_ready,
    output lru_pkg::lru_cmd_t cmd
);
    import lru_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lru_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lru_dpath (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  lru_pkg::lru_cmd_t      cmd,
    input  wire                          cfg_we,
    input  wire  [lru_pkg::CAP_W-1:0]    cfg_data,
    input  wire                          s_func,
    input  wire  [lru_pkg::KEY_W-1:0]    s_key,
    input  wire  [lru_pkg::DATA_W-1:0]   s_value,
    output logic                         m_hit,
    output logic [lru_pkg::DATA_W-1:0]   m_value_out,
    output logic                         m_evicted,
    output logic [lru_pkg::KEY_W-1:0]    m_evicted_key
);
    import lru_pkg::*;

    // entry store: tags compared in parallel, no reset on tag/data
    logic [TAG_BITS-1:0] tag_reg  [ENTRIES];
    logic [DATA_W-1:0]   data_reg [ENTRIES];
    entry_vec_t          valid_reg, valid_next;
    logic [IDX_W-1:0]    rank_reg [ENTRIES];
    logic [IDX_W-1:0]    rank_next [ENTRIES];
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CAP_W-1:0]    cap_reg;

    // captured item
    logic                func_reg;
    logic [TAG_BITS-1:0] key_reg;
    logic [DATA_W-1:0]   value_reg;

    // search results
    entry_vec_t          match_reg, old_reg, second_reg, free_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    match_rank_reg;

    entry_vec_t          match_vec, old_vec, second_vec, free_vec, invalid_vec;
    logic [IDX_W-1:0]    match_rank;
    logic [CNT_W-1:0]    fill_m1, fill_m2;

    // update
    logic [CNT_W-1:0]    cap_eff;
    logic                ins_hit, ins_miss, look_hit, evict_en;
    entry_vec_t          victim_vec, slot_vec;
    logic [DATA_W-1:0]   hit_data;
    logic [TAG_BITS-1:0] victim_tag;

    // search stage
    assign fill_m1     = fill_reg - CNT_W'(1);
    assign fill_m2     = fill_reg - CNT_W'(2);
    assign invalid_vec = ~valid_reg;
    assign free_vec    = invalid_vec & (~invalid_vec + entry_vec_t'(1));

    always_comb begin
        match_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i]  = valid_reg[i] && (tag_reg[i] == key_reg);
            // valid ranks are a permutation of 0..fill-1
            old_vec[i]    = valid_reg[i] && (CNT_W'(rank_reg[i]) == fill_m1);
            second_vec[i] = valid_reg[i] && (CNT_W'(rank_reg[i]) == fill_m2);
            if (match_vec[i]) begin
                match_rank = match_rank | rank_reg[i];
            end
        end
    end

    // update stage
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(cap_reg) > ENTRIES) begin
            cap_eff = CNT_W'(ENTRIES);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign look_hit = (func_reg == FUNC_LOOKUP) && hit_reg;
    assign ins_hit  = (func_reg == FUNC_INSERT) && hit_reg;
    assign ins_miss = (func_reg == FUNC_INSERT) && !hit_reg;

    always_comb begin
        evict_en = 1'b0;
        if (ins_hit) begin
            evict_en = (fill_reg > cap_eff);
        end else if (ins_miss) begin
            evict_en = (fill_reg >= cap_eff) || (int'(fill_reg) >= ENTRIES);
        end
        // when the hit entry was least recent, promotion moves the
        // second-oldest into the LRU position
        if (!evict_en) begin
            victim_vec = '0;
        end else if (ins_hit && (match_reg == old_reg)) begin
            victim_vec = second_reg;
        end else begin
            victim_vec = old_reg;
        end
        slot_vec = evict_en ? old_reg : free_reg;
    end

    always_comb begin
        hit_data   = '0;
        victim_tag = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_reg[i]) begin
                hit_data = hit_data | data_reg[i];
            end
            if (victim_vec[i]) begin
                victim_tag = victim_tag | tag_reg[i];
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        fill_next  = fill_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
            if (look_hit || ins_hit) begin
                if (match_reg[i]) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (rank_reg[i] < match_rank_reg)) begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
                if (victim_vec[i]) begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
            end else if (ins_miss) begin
                if (slot_vec[i]) begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end else if (valid_reg[i]) begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
        end
        if (ins_hit && evict_en) begin
            fill_next = fill_reg - CNT_W'(1);
        end else if (ins_miss && !evict_en) begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= '0;
            cap_reg   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_data;
            end
            if (cmd.update) begin
                valid_reg <= valid_next;
                fill_reg  <= fill_next;
                for (int i = 0; i < ENTRIES; i++) begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= s_func;
            key_reg   <= s_key[TAG_BITS-1:0];
            value_reg <= s_value;
        end
        if (cmd.search) begin
            match_reg      <= match_vec;
            old_reg        <= old_vec;
            second_reg     <= second_vec;
            free_reg       <= free_vec;
            hit_reg        <= |match_vec;
            match_rank_reg <= match_rank;
        end
        if (cmd.update) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (ins_miss && slot_vec[i]) begin
                    tag_reg[i]  <= key_reg;
                    data_reg[i] <= value_reg;
                end else if (ins_hit && match_reg[i]) begin
                    data_reg[i] <= value_reg;
                end
            end
            m_hit         <= hit_reg;
            m_value_out   <= look_hit ? hit_data : '0;
            m_evicted     <= evict_en;
            m_evicted_key <= KEY_W'(victim_tag);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lru_lookup_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fully associative LRU cache of 16 key/value entries. An item is a lookup
// (s_func 0) or an insert (s_func 1); each gives exactly one result. The item
// is captured at the edge that accepts it; the next cycle does the parallel tag
// compare and LRU search over all entries, and the update state that follows
// does the rank/valid update and registers the result once the output register
// is free. The controller handles one item at a time, so a new item is not
// accepted until the previous one has finished its update; the input is taken
// again while the previous result still waits in the output register, and that
// next item then holds in its update state until the waiting result is taken.
// Capacity (cfg_data, reset 16) may be written any time the block is idle;
// 0 acts as 1 and values above 16 act as 16. Lowering it drops nothing at once:
// each later insert evicts at most one least recent entry.
module lru_lookup_cache (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [lru_pkg::CAP_W-1:0]    cfg_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_func,
    input  wire  [lru_pkg::KEY_W-1:0]    s_key,
    input  wire  [lru_pkg::DATA_W-1:0]   s_value,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_hit,
    output logic [lru_pkg::DATA_W-1:0]   m_value_out,
    output logic                         m_evicted,
    output logic [lru_pkg::KEY_W-1:0]    m_evicted_key
);
    import lru_pkg::*;

    lru_cmd_t cmd;

    assign cfg_ready = 1'b1;

    lru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lru_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .s_func        (s_func),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_hit         (m_hit),
        .m_value_out   (m_value_out),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

endmodule

`default_nettype wire

// ----- hdl/lru_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lru_checker (
    input wire                        aclk,
    input wire                        aresetn,
    input wire                        m_valid,
    input wire                        m_ready,
    input wire                        m_hit,
    input wire [lru_pkg::DATA_W-1:0]  m_value_out,
    input wire                        m_evicted,
    input wire [lru_pkg::KEY_W-1:0]   m_evicted_key
);
    import lru_pkg::*;

    // no result right out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a result waiting for the sink stays put
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_evicted_key) && $stable(m_value_out))
        else $error("result payload changed while stalled");

    // evicted key is zero unless something was evicted
    a_evict_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted |-> m_evicted_key == '0)
        else $error("evicted key without eviction");

    // data only comes back on a lookup hit, which never evicts
    a_value_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_value_out != '0) |-> m_hit && !m_evicted)
        else $error("value returned without lookup hit");

endmodule

bind lru_lookup_cache lru_checker u_lru_checker (.*);

`default_nettype wire
